[design/tsf_pkg.sv]
// shared constants, transaction types and sequencer states for the substring find engine
package tsf_pkg;

	localparam int TEXT_DEPTH    = 16384;
	localparam int PATTERN_DEPTH = 64;
	localparam int TEXT_AW       = $clog2(TEXT_DEPTH);
	localparam int PAT_AW        = $clog2(PATTERN_DEPTH);
	localparam int SCAN_W        = (TEXT_AW + 1 > 15) ? TEXT_AW + 1 : 15;
	localparam int PL_W          = (PAT_AW + 1 > 7) ? PAT_AW + 1 : 7;
	localparam int APB_AW        = 3;

	localparam logic [2:0] REQ_WR_TEXT = 3'd0;
	localparam logic [2:0] REQ_WR_PAT  = 3'd1;
	localparam logic [2:0] REQ_FIND    = 3'd2;
	localparam logic [2:0] REQ_COUNT   = 3'd3;
	localparam logic [2:0] REQ_ORD     = 3'd4;

	localparam logic REG_TEXT_LEN = 1'b0;
	localparam logic REG_PAT_LEN  = 1'b1;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [13:0] text_address;
		logic [5:0]  pattern_index;
		logic [7:0]  byte_value;
		logic [13:0] search_position;
	} in_item_t;

	typedef struct packed {
		logic        found;
		logic [13:0] match_position;
		logic [13:0] match_count;
		logic [13:0] match_ordinal;
	} out_item_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_FETCH,
		S_CMP,
		S_NEXT,
		S_DONE
	} scan_state_t;

	typedef struct packed {
		logic start;
		logic take;
	} scan_ctl_t;

	typedef struct packed {
		logic idle;
		logic done;
	} scan_stat_t;

endpackage

[design/tsf_ram.sv]
// generic single write port, single read port ram with registered read data
module tsf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[design/tsf_scan.sv]
// scan sequencer with the shared byte compare unit, position and match counters
module tsf_scan import tsf_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  scan_ctl_t           ctl,
	input  in_item_t            req,
	input  logic [13:0]         text_length,
	input  logic [5:0]          pattern_length,
	output scan_stat_t          stat,
	output out_item_t           result,
	output logic [TEXT_AW-1:0]  text_raddr,
	input  logic [7:0]          text_rdata,
	output logic [PAT_AW-1:0]   pat_raddr,
	input  logic [7:0]          pat_rdata
);

	scan_state_t       state_q, state_d;
	logic [2:0]        op_q;
	logic [SCAN_W-1:0] spos_q;
	logic [SCAN_W-1:0] last_q;
	logic              none_q;
	logic [PL_W-1:0]   plen_q;
	logic [SCAN_W-1:0] pos_q;
	logic [PL_W-1:0]   k_q;
	logic              phase_q;
	logic              hit_q;
	logic [SCAN_W-1:0] cnt_q;
	logic              found_q;
	logic              hit_spos_q;

	logic [SCAN_W-1:0] tl;
	logic [SCAN_W-1:0] tlen_eff;
	logic [PL_W-1:0]   pl;
	logic [PL_W-1:0]   plen_eff;
	logic              is_search;
	logic              pos_ok;
	logic              byte_eq;
	logic              last_byte;
	logic [PL_W-1:0]   k_next;
	logic [PL_W-1:0]   addr_k;

	assign tl        = SCAN_W'(text_length);
	assign tlen_eff  = (tl > SCAN_W'(TEXT_DEPTH)) ? SCAN_W'(TEXT_DEPTH) : tl;
	assign pl        = PL_W'(pattern_length);
	assign plen_eff  = (pl > PL_W'(PATTERN_DEPTH)) ? PL_W'(PATTERN_DEPTH) : pl;
	assign is_search = (req.req_type == REQ_FIND) || (req.req_type == REQ_COUNT)
		|| (req.req_type == REQ_ORD);
	assign byte_eq   = (text_rdata == pat_rdata);
	assign k_next    = k_q + 1'b1;
	assign last_byte = (k_next == plen_q);

	always_comb begin
		pos_ok = !none_q && (pos_q <= last_q);
		if (op_q == REQ_FIND && phase_q) begin
			pos_ok = pos_ok && (pos_q < spos_q);
		end else if (op_q == REQ_ORD) begin
			pos_ok = pos_ok && (pos_q <= spos_q);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (ctl.start) begin
					state_d = is_search ? S_CHECK : S_DONE;
				end
			end
			S_CHECK: begin
				if (pos_ok) begin
					state_d = S_FETCH;
				end else if (op_q == REQ_FIND && !phase_q) begin
					state_d = S_CHECK;
				end else begin
					state_d = S_DONE;
				end
			end
			S_FETCH: state_d = S_CMP;
			S_CMP: begin
				if (!byte_eq || last_byte) begin
					state_d = S_NEXT;
				end
			end
			S_NEXT: begin
				state_d = (hit_q && op_q == REQ_FIND) ? S_DONE : S_CHECK;
			end
			S_DONE: begin
				if (ctl.take) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		stat.idle  = (state_q == S_IDLE);
		stat.done  = (state_q == S_DONE);
		addr_k     = (state_q == S_CMP) ? k_next : k_q;
		text_raddr = TEXT_AW'(pos_q + SCAN_W'(addr_k));
		pat_raddr  = PAT_AW'(addr_k);
		result.found          = found_q;
		result.match_position = found_q ? 14'(pos_q) : 14'd0;
		result.match_count    = (op_q == REQ_COUNT) ? 14'(cnt_q) : 14'd0;
		result.match_ordinal  = (op_q == REQ_ORD && hit_spos_q) ? 14'(cnt_q) : 14'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (ctl.start) begin
					op_q       <= req.req_type;
					spos_q     <= SCAN_W'(req.search_position);
					last_q     <= tlen_eff - SCAN_W'(plen_eff);
					none_q     <= (plen_eff == '0) || (SCAN_W'(plen_eff) > tlen_eff);
					plen_q     <= plen_eff;
					pos_q      <= (req.req_type == REQ_FIND) ? SCAN_W'(req.search_position)
						: '0;
					phase_q    <= 1'b0;
					cnt_q      <= '0;
					found_q    <= 1'b0;
					hit_spos_q <= 1'b0;
					hit_q      <= 1'b0;
					k_q        <= '0;
				end
			end
			S_CHECK: begin
				k_q <= '0;
				if (!pos_ok && op_q == REQ_FIND && !phase_q) begin
					phase_q <= 1'b1;
					pos_q   <= '0;
				end
			end
			S_CMP: begin
				if (byte_eq && !last_byte) begin
					k_q <= k_next;
				end else begin
					hit_q <= byte_eq;
				end
			end
			S_NEXT: begin
				if (hit_q) begin
					cnt_q <= cnt_q + 1'b1;
					if (op_q == REQ_FIND) begin
						found_q <= 1'b1;
					end
					if (op_q == REQ_ORD && pos_q == spos_q) begin
						hit_spos_q <= 1'b1;
					end
				end
				if (!(hit_q && op_q == REQ_FIND)) begin
					pos_q <= pos_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	a_start_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE && ctl.start |=> state_q != S_IDLE)
		else $error("scan did not leave idle after a transaction");

	a_cmp_in_text: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CMP |-> (pos_q + SCAN_W'(k_q)) < (last_q + SCAN_W'(plen_q)))
		else $error("compare reads beyond the text length");

	a_cnt_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_NEXT |-> cnt_q <= pos_q)
		else $error("match count exceeds scanned positions");

	a_found_valid: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE && found_q |-> op_q == REQ_FIND && !none_q && pos_q <= last_q)
		else $error("reported match outside the candidate range");

endmodule

[design/text_substring_find_engine.sv]
// top level: handshake, register port, text and pattern stores, output register
// One transaction at a time. A text or pattern byte write goes to the done state and presents
// its all-zero result when the output register is free, and the next transaction can be
// accepted as soon as that result is presented. A find, count or ordinal transaction walks
// the candidate offsets with one byte compare per cycle within an offset against the single
// text read port: each offset tried passes through the check, fetch, compare and next
// states, comparing one pattern byte at a time and stopping at the first mismatch.
// Find-next stops at the first match. The text store is 16384 bytes and the pattern
// store 64 bytes; both are undefined until written, and a search must only cover entries
// already written.
// Registers: text_length at byte address 0, pattern_length at byte address 4.
module text_substring_find_engine import tsf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  in_item_t          in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output out_item_t         out_data,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	logic [13:0]        text_len_q;
	logic [5:0]         pat_len_q;
	logic               out_valid_q;
	out_item_t          out_data_q;
	scan_ctl_t          ctl;
	scan_stat_t         stat;
	out_item_t          result;
	logic               in_acc;
	logic               cfg_wr;
	logic               text_we;
	logic               pat_we;
	logic [TEXT_AW-1:0] text_raddr;
	logic [7:0]         text_rdata;
	logic [PAT_AW-1:0]  pat_raddr;
	logic [7:0]         pat_rdata;

	assign pready    = 1'b1;
	assign cfg_wr    = psel && penable && pwrite && pready;
	assign prdata    = (paddr[2] == REG_PAT_LEN) ? {26'd0, pat_len_q} : {18'd0, text_len_q};
	assign in_ready  = stat.idle;
	assign in_acc    = in_valid && in_ready;
	assign ctl.start = in_acc;
	assign ctl.take  = stat.done && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign text_we   = in_acc && (in_data.req_type == REQ_WR_TEXT)
		&& (32'(in_data.text_address) < 32'(TEXT_DEPTH));
	assign pat_we    = in_acc && (in_data.req_type == REQ_WR_PAT)
		&& (32'(in_data.pattern_index) < 32'(PATTERN_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_len_q <= '0;
			pat_len_q  <= '0;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_PAT_LEN) begin
				pat_len_q <= pwdata[5:0];
			end else begin
				text_len_q <= pwdata[13:0];
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.take) begin
			out_data_q <= result;
		end
	end

	tsf_ram #(
		.WIDTH (8),
		.DEPTH (TEXT_DEPTH)
	) u_text_ram (
		.clk   (clk),
		.we    (text_we),
		.waddr (TEXT_AW'(in_data.text_address)),
		.wdata (in_data.byte_value),
		.raddr (text_raddr),
		.rdata (text_rdata)
	);

	tsf_ram #(
		.WIDTH (8),
		.DEPTH (PATTERN_DEPTH)
	) u_pat_ram (
		.clk   (clk),
		.we    (pat_we),
		.waddr (PAT_AW'(in_data.pattern_index)),
		.wdata (in_data.byte_value),
		.raddr (pat_raddr),
		.rdata (pat_rdata)
	);

	tsf_scan u_scan (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl            (ctl),
		.req            (in_data),
		.text_length    (text_len_q),
		.pattern_length (pat_len_q),
		.stat           (stat),
		.result         (result),
		.text_raddr     (text_raddr),
		.text_rdata     (text_rdata),
		.pat_raddr      (pat_raddr),
		.pat_rdata      (pat_rdata)
	);

endmodule

[tb/tsf_check_pkg.sv]
// scoreboard class that predicts and checks substring find engine results
package tsf_check_pkg;
	import tsf_pkg::*;

	class find_scoreboard;
		logic [7:0] text_mem [TEXT_DEPTH];
		logic [7:0] pat_mem [PATTERN_DEPTH];
		int text_len;
		int pat_len;
		out_item_t awaited [$];
		int errors;

		function new();
			text_len = 0;
			pat_len = 0;
			errors = 0;
		endfunction

		function void set_register(logic idx, int value);
			if (idx == REG_TEXT_LEN) begin
				text_len = value;
			end else begin
				pat_len = value;
			end
		endfunction

		function bit hit_at(int pos);
			for (int k = 0; k < pat_len; k++) begin
				if (text_mem[pos + k] !== pat_mem[k]) return 1'b0;
			end
			return 1'b1;
		endfunction

		function out_item_t search_outcome(in_item_t it);
			out_item_t r;
			int n;
			int spos;
			r = '0;
			n = 0;
			spos = it.search_position;
			case (it.req_type)
			REQ_WR_TEXT: begin
				text_mem[it.text_address] = it.byte_value;
			end
			REQ_WR_PAT: begin
				pat_mem[it.pattern_index] = it.byte_value;
			end
			REQ_FIND: begin
				if (pat_len > 0) begin
					for (int p = spos; p + pat_len <= text_len && !r.found; p++) begin
						if (hit_at(p)) begin
							r.found = 1'b1;
							r.match_position = 14'(p);
						end
					end
					for (int p = 0; p + pat_len <= text_len && p < spos && !r.found; p++) begin
						if (hit_at(p)) begin
							r.found = 1'b1;
							r.match_position = 14'(p);
						end
					end
				end
			end
			REQ_COUNT: begin
				if (pat_len > 0) begin
					for (int p = 0; p + pat_len <= text_len; p++) begin
						if (hit_at(p)) n++;
					end
				end
				r.match_count = 14'(n);
			end
			REQ_ORD: begin
				if (pat_len > 0) begin
					for (int p = 0; p + pat_len <= text_len && p <= spos; p++) begin
						if (hit_at(p)) begin
							n++;
							if (p == spos) r.match_ordinal = 14'(n);
						end
					end
				end
			end
			default: begin
			end
			endcase
			return r;
		endfunction

		function void note_request(in_item_t it);
			awaited.push_back(search_outcome(it));
		endfunction

		task report(string text);
			errors++;
			$display("mismatch: %s", text);
		endtask

		task check_result(out_item_t got);
			out_item_t want;
			if (awaited.size() == 0) begin
				report($sformatf("result %h with no request pending", got));
				return;
			end
			want = awaited.pop_front();
			if (got.found !== want.found)
				report($sformatf("found got %0d expected %0d", got.found, want.found));
			if (got.match_position !== want.match_position)
				report($sformatf("match_position got %0d expected %0d",
					got.match_position, want.match_position));
			if (got.match_count !== want.match_count)
				report($sformatf("match_count got %0d expected %0d",
					got.match_count, want.match_count));
			if (got.match_ordinal !== want.match_ordinal)
				report($sformatf("match_ordinal got %0d expected %0d",
					got.match_ordinal, want.match_ordinal));
		endtask
	endclass

endpackage

[tb/tb.sv]
// testbench top: drives requests and register writes into the substring find engine
module tb;
	import tsf_pkg::*;
	import tsf_check_pkg::*;

	localparam int CYCLE_LIMIT = 4000000;
	localparam int HOLD_CYCLES = 400;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	in_item_t          in_data;
	logic              out_valid;
	logic              out_ready;
	out_item_t         out_data;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;

	find_scoreboard sb;
	logic [7:0] text_image [TEXT_DEPTH];
	bit quiet;
	bit hold_ask;
	int hold_left;
	int rx_gap;
	int cycle_count;

	text_substring_find_engine i_dut (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) sb.check_result(out_data);
			if (in_valid && in_ready) sb.note_request(in_data);
		end
	end

	function automatic int idle_len();
		int r;
		if (quiet) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(30, 80);
	endfunction

	// receiver side: random stalls plus one long hold-off on request
	initial begin
		hold_left = 0;
		rx_gap = 0;
		forever begin
			@(negedge clk);
			if (hold_ask) begin
				hold_ask = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				out_ready = 1'b0;
				hold_left--;
			end else if (rx_gap > 0) begin
				out_ready = 1'b0;
				rx_gap--;
			end else begin
				out_ready = 1'b1;
				if (!quiet && $urandom_range(0, 3) == 0) rx_gap = idle_len();
			end
		end
	end

	function automatic in_item_t noise_item();
		in_item_t it;
		it.req_type = 3'($urandom);
		it.text_address = 14'($urandom);
		it.pattern_index = 6'($urandom);
		it.byte_value = 8'($urandom);
		it.search_position = 14'($urandom);
		return it;
	endfunction

	function automatic logic [7:0] glyph(int span);
		if ($urandom_range(0, 15) == 0) return 8'($urandom);
		return 8'h61 + 8'($urandom_range(0, span - 1));
	endfunction

	task automatic send_transaction(in_item_t it);
		int gap;
		gap = idle_len();
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		in_data = it;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic put_text(int addr, logic [7:0] val);
		in_item_t it;
		it = noise_item();
		it.req_type = REQ_WR_TEXT;
		it.text_address = 14'(addr);
		it.byte_value = val;
		text_image[addr] = val;
		send_transaction(it);
	endtask

	task automatic put_pattern(int idx, logic [7:0] val);
		in_item_t it;
		it = noise_item();
		it.req_type = REQ_WR_PAT;
		it.pattern_index = 6'(idx);
		it.byte_value = val;
		send_transaction(it);
	endtask

	task automatic ask(logic [2:0] kind, int spos);
		in_item_t it;
		it = noise_item();
		it.req_type = kind;
		it.search_position = 14'(spos);
		send_transaction(it);
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (sb.awaited.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, int value);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = APB_AW'({idx, 2'b00});
		pwdata = 32'(value);
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_register(idx, value);
		@(negedge clk);
		pwrite = 1'b0;
		penable = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== 32'(value))
			sb.report($sformatf("register %0d reads %0d expected %0d", idx, prdata, value));
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	task automatic load_phase(int len_text, int len_pat, int span);
		int s;
		bit copy;
		for (int i = 0; i < len_text; i++) put_text(i, glyph(span));
		copy = len_pat > 0 && len_pat <= len_text && $urandom_range(0, 1) == 1;
		s = copy ? $urandom_range(0, len_text - len_pat) : 0;
		for (int k = 0; k < len_pat; k++) put_pattern(k, copy ? text_image[s + k] : glyph(span));
		drain();
		write_reg(REG_TEXT_LEN, len_text);
		write_reg(REG_PAT_LEN, len_pat);
	endtask

	task automatic mix_traffic(int len_text, int span, int n);
		in_item_t it;
		int r;
		int spos;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if ($urandom_range(0, 4) == 0) spos = int'(14'($urandom));
			else spos = $urandom_range(0, len_text + 2);
			if (r < 25) ask(REQ_FIND, spos);
			else if (r < 42) ask(REQ_COUNT, spos);
			else if (r < 62) ask(REQ_ORD, spos);
			else if (r < 72 && len_text > 0) put_text($urandom_range(0, len_text - 1), glyph(span));
			else if (r < 80) put_text(int'(14'($urandom)), 8'($urandom));
			else if (r < 92) put_pattern(int'(6'($urandom)), glyph(span));
			else begin
				it = noise_item();
				it.req_type = REQ_ORD + 3'($urandom_range(1, 3));
				send_transaction(it);
			end
		end
	endtask

	initial begin
		int len_text;
		int len_pat;
		int span;
		int r;
		in_item_t it;
		string seed_text;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		quiet = 1'b0;
		hold_ask = 1'b0;
		sb = new();
		seed_text = "abaababaab";
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty stores and zero lengths
		ask(REQ_FIND, 0);
		ask(REQ_COUNT, 0);
		ask(REQ_ORD, 0);
		for (int k = 1; k <= 3; k++) begin
			it = noise_item();
			it.req_type = REQ_ORD + 3'(k);
			send_transaction(it);
		end
		put_text(TEXT_DEPTH - 1, 8'hFF);
		put_text(0, 8'h00);
		put_pattern(PATTERN_DEPTH - 1, 8'hFF);
		put_pattern(0, 8'h00);

		// overlapping matches, wrap-around and start beyond the text
		for (int i = 0; i < seed_text.len(); i++) put_text(i, seed_text[i]);
		for (int k = 0; k < 3; k++) put_pattern(k, seed_text[k]);
		drain();
		write_reg(REG_TEXT_LEN, seed_text.len());
		write_reg(REG_PAT_LEN, 3);
		ask(REQ_COUNT, 0);
		ask(REQ_FIND, 0);
		ask(REQ_FIND, 1);
		ask(REQ_FIND, 6);
		ask(REQ_FIND, 8);
		ask(REQ_FIND, TEXT_DEPTH - 1);
		ask(REQ_ORD, 5);
		ask(REQ_ORD, 4);
		ask(REQ_ORD, TEXT_DEPTH - 1);
		drain();
		// pattern longer than text
		write_reg(REG_TEXT_LEN, 2);
		ask(REQ_COUNT, 0);
		ask(REQ_FIND, 0);
		ask(REQ_ORD, 0);
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			quiet = (ph == 1);
			span = $urandom_range(1, 3);
			len_text = $urandom_range(0, 12);
			r = $urandom_range(0, 99);
			if (ph == 0) begin
				len_text = 12;
				len_pat = 7;
			end else if (r < 10) begin
				len_pat = 0;
			end else if (r < 25) begin
				len_pat = len_text + $urandom_range(1, 4);
				if (len_pat > PATTERN_DEPTH - 1) len_pat = PATTERN_DEPTH - 1;
			end else begin
				len_pat = $urandom_range(1, 5);
			end
			load_phase(len_text, len_pat, span);
			if (ph == 2) begin
				mix_traffic(len_text, span, 3);
				hold_ask = 1'b1;
				mix_traffic(len_text, span, 5);
			end else if (ph == 3) begin
				mix_traffic(len_text, span, 4);
				drain();
				mix_traffic(len_text, span, 4);
			end else begin
				mix_traffic(len_text, span, 8);
			end
			drain();
		end

		repeat (20) @(posedge clk);
		if (sb.awaited.size() != 0)
			sb.report($sformatf("%0d results never arrived", sb.awaited.size()));
		if (sb.errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
